// ===== src/lifo_stack_with_peek_defines.svh =====
// Assertion helpers used by the checker.
`ifndef LIFO_STACK_WITH_PEEK_DEFINES_SVH
`define LIFO_STACK_WITH_PEEK_DEFINES_SVH

// Check on every clock edge outside reset.
`define LSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Check on every clock edge, reset included.
`define LSP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/lsp_pkg.sv =====
`timescale 1ns / 1ps
package lsp_pkg;

  localparam int DEPTH     = 8;
  localparam int DATA_W    = 32;
  localparam int POS_W     = 4;
  localparam int CAP_W     = 4;
  localparam int CMD_W     = 2;
  localparam int STAT_W    = 2;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TDATA_W   = ((DATA_W + POS_W + 7) / 8) * 8;
  localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_PEEK = 2'd2,
    CMD_TRAV = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_BADPOS   = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EMIT = 1'b1
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

// ===== src/lsp_store.sv =====
`timescale 1ns / 1ps
module lsp_store (
  input  logic                    clk,
  input  lsp_pkg::mem_req_t       req,
  output logic [lsp_pkg::DATA_W-1:0] rd_data
);
  import lsp_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule

// ===== src/lifo_stack_with_peek.sv =====
`timescale 1ns / 1ps
// LIFO stack of signed 32-bit words with peek and traverse.
// Input channel in_*: one command per transfer; in_tuser carries the command
// (push, pop, peek, traverse), in_tdata the push word and the peek position.
// Result channel out_*: out_tuser carries the status, out_tdata the word and
// its position from the top, out_tlast marks the final result of a command.
// Push, pop and peek give one result; traverse gives one result per stored
// word, top first, or a single empty status on an empty stack.
// The words sit in a single-port-read memory with a registered read. A
// command is taken while idle, its word is read into the memory's read
// register, and its result moves to the output register once that is free;
// in_tready stays low while a command is in flight.
// A result waiting in the output register does not block the next command.
// When the receiver stalls, out_* hold; a traverse pauses until the slot drains.
// cfg_wr_data sets the usable capacity (0 acts as 1, above the depth as depth).
// Reset empties the stack and sets the capacity to 8; the memory is not
// cleared, since only written words ever reach the output.
module lifo_stack_with_peek (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [lsp_pkg::CAP_W-1:0]   cfg_wr_data,   // capacity
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [lsp_pkg::TDATA_W-1:0] in_tdata,      // push_value, peek_position
  input  logic [lsp_pkg::CMD_W-1:0]   in_tuser,      // cmd
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [lsp_pkg::TDATA_W-1:0] out_tdata,     // data_out, entry_position
  output logic [lsp_pkg::STAT_W-1:0]  out_tuser,     // status
  output logic                        out_tlast      // last
);
  import lsp_pkg::*;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CAP_W-1:0]  cap_r;
  logic [CNT_W-1:0]  cap_eff;

  cmd_t              cmd;
  logic [DATA_W-1:0] in_val;
  logic [POS_W-1:0]  in_pos;
  logic              accept, full, empty, pos_bad;
  logic [CNT_W-1:0]  count_m1, peek_diff;

  // pending result
  status_t           res_status_r, acc_status;
  logic [POS_W-1:0]  res_pos_r, acc_pos;
  logic              res_last_r, acc_last;
  logic              res_den_r, acc_den;
  logic [ADDR_W-1:0] idx_r;

  // output register
  logic              out_valid_r;
  status_t           out_status_r;
  logic [DATA_W-1:0] out_data_r;
  logic [POS_W-1:0]  out_pos_r;
  logic              out_last_r;

  logic              load, more;
  mem_req_t          mreq;
  logic [DATA_W-1:0] rd_data;

  assign cmd    = cmd_t'(in_tuser);
  assign in_val = in_tdata[DATA_W-1:0];
  assign in_pos = in_tdata[DATA_W +: POS_W];
  assign accept = in_tvalid && in_tready;

  // clamp the capacity register into 1..DEPTH
  always_comb begin
    priority if (cap_r == '0) begin
      cap_eff = CNT_W'(1);
    end else if (cap_r > CAP_W'(DEPTH)) begin
      cap_eff = CNT_W'(DEPTH);
    end else begin
      cap_eff = CNT_W'(cap_r);
    end
  end

  assign full      = (count_r >= cap_eff) || (count_r >= CNT_W'(DEPTH));
  assign empty     = (count_r == '0);
  assign pos_bad   = (in_pos == '0) || (in_pos > count_r);
  assign count_m1  = count_r - CNT_W'(1);
  assign peek_diff = CNT_W'(count_r - in_pos);

  // FSM: next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = S_EMIT;
      S_EMIT: if (load && res_last_r) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // FSM: outputs
  always_comb begin
    in_tready = 1'b0;
    load      = 1'b0;
    unique case (state_r)
      S_IDLE: in_tready = 1'b1;
      S_EMIT: load = !out_valid_r || out_tready;
      default: in_tready = 1'b0;
    endcase
  end

  // a traverse still has words to go
  assign more = load && !res_last_r;

  // decode the command against the current fill
  always_comb begin
    acc_status = ST_OK;
    acc_pos    = '0;
    acc_last   = 1'b1;
    acc_den    = 1'b0;
    count_nxt  = count_r;
    unique case (cmd)
      CMD_PUSH: begin
        if (full) begin
          acc_status = ST_OVERFLOW;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      CMD_POP: begin
        if (empty) begin
          acc_status = ST_EMPTY;
        end else begin
          acc_pos   = POS_W'(1);
          acc_den   = 1'b1;
          count_nxt = count_m1;
        end
      end
      CMD_PEEK: begin
        if (empty) begin
          acc_status = ST_EMPTY;
        end else if (pos_bad) begin
          acc_status = ST_BADPOS;
        end else begin
          acc_pos = in_pos;
          acc_den = 1'b1;
        end
      end
      CMD_TRAV: begin
        if (empty) begin
          acc_status = ST_EMPTY;
        end else begin
          acc_pos  = POS_W'(1);
          acc_den  = 1'b1;
          acc_last = (count_r == CNT_W'(1));
        end
      end
      default: acc_status = ST_OK;
    endcase
  end

  // memory access: push writes at the fill level, the rest read
  always_comb begin
    mreq.we    = accept && (cmd == CMD_PUSH) && !full;
    mreq.waddr = count_r[ADDR_W-1:0];
    mreq.wdata = in_val;
    mreq.re    = (accept && (cmd != CMD_PUSH)) || more;
    if (more) begin
      mreq.raddr = idx_r - ADDR_W'(1);
    end else if (cmd == CMD_PEEK) begin
      mreq.raddr = peek_diff[ADDR_W-1:0];
    end else begin
      mreq.raddr = count_m1[ADDR_W-1:0];
    end
  end

  lsp_store u_store (
    .clk     (clk),
    .req     (mreq),
    .rd_data (rd_data)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (accept) begin
        count_r <= count_nxt;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // pending result: set on accept, advance per traversed word
  always_ff @(posedge clk) begin
    if (accept) begin
      res_status_r <= acc_status;
      res_pos_r    <= acc_pos;
      res_last_r   <= acc_last;
      res_den_r    <= acc_den;
      idx_r        <= mreq.raddr;
    end else if (more) begin
      idx_r      <= mreq.raddr;
      res_pos_r  <= res_pos_r + POS_W'(1);
      res_last_r <= (CNT_W'(res_pos_r + POS_W'(1)) == count_r);
    end
  end

  // output register: drop the read word into the slot when it frees up
  always_ff @(posedge clk) begin
    if (load) begin
      out_status_r <= res_status_r;
      out_data_r   <= res_den_r ? rd_data : '0;
      out_pos_r    <= res_pos_r;
      out_last_r   <= res_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDATA_W'({out_pos_r, out_data_r});
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== src/lsp_checker.sv =====
`timescale 1ns / 1ps
`include "lifo_stack_with_peek_defines.svh"
module lsp_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [lsp_pkg::TDATA_W-1:0] out_tdata,
  input logic [lsp_pkg::STAT_W-1:0]  out_tuser,
  input logic                        out_tlast
);
  import lsp_pkg::*;

  logic [TDATA_W+STAT_W:0] out_bus;
  logic                    out_stall;
  logic                    out_err;

  assign out_bus   = {out_tlast, out_tuser, out_tdata};
  assign out_stall = out_tvalid && !out_tready;
  assign out_err   = out_tvalid && (out_tuser != ST_OK);

  // a stalled result holds
  `LSP_ASSERT(a_out_hold, out_stall |=> out_tvalid && $stable(out_bus), "stalled result changed")

  // an error status is always a lone, empty result
  `LSP_ASSERT(a_err_alone, out_err |-> out_tlast && (out_tdata == '0), "bad error result")

  // one command in flight at a time
  `LSP_ASSERT(a_one_cmd, in_tvalid && in_tready |=> !in_tready, "second command taken")

  // reset empties the result slot
  `LSP_ASSERT_RST(a_rst_empty, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind lifo_stack_with_peek lsp_checker u_lsp_checker (.*);
